>>> rtl/sirs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sirs_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int DIGIT_SLOTS = 32;
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int VALUE_W     = 32;
    localparam int CHUNK_BITS  = 8;
    localparam int DIV_CHUNKS  = VALUE_W / CHUNK_BITS;

    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'(MAX_SYMBOLS);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] REG_RADIX  = 2'd0;
    localparam logic [1:0] REG_SYM_LO = 2'd1;
    localparam logic [1:0] REG_SYM_HI = 2'd2;

    localparam logic [4:0]  RADIX_RST  = 5'd10;
    localparam logic [63:0] SYM_LO_RST = 64'h3736353433323130;
    localparam logic [63:0] SYM_HI_RST = 64'h4645444342413938;

    typedef struct packed {
        logic                 neg;
        logic [VALUE_W-1:0]   mag;
    } t_item;

    typedef struct packed {
        logic [4:0]   radix;
        logic [127:0] syms;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char;

    function automatic logic [7:0] sym_at(logic [127:0] syms, logic [3:0] k);
        logic [6:0] base;
        base = {k, 3'b000};
        return syms[base +: 8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sirs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sirs_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic signed [31:0]  i_value,
    input  wire logic                i_take,
    output logic                     o_valid,
    output sirs_pkg::t_item          o_item
);

    sirs_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    sirs_pkg::t_item w_item;
    logic            w_wr;
    logic            w_rd;

    // sign split and magnitude, most negative value maps onto itself
    always_comb begin
        w_item.neg = i_value[31];
        w_item.mag = i_value[31] ? (32'd0 - 32'(i_value)) : 32'(i_value);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sirs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sirs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sirs_pkg::t_cfg    i_cfg,
    input  wire logic              i_alpha_ok,
    input  wire logic              i_valid,
    input  wire sirs_pkg::t_item   i_item,
    output logic                   o_take,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [7:0]             o_char_out,
    output logic                   o_last_char
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SIGN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int CW = sirs_pkg::CNT_W;
    localparam int IW = sirs_pkg::IDX_W;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    logic [31:0]    r_work;
    logic [31:0]    n_work;
    logic [3:0]     r_rem;
    logic [3:0]     n_rem;
    logic [1:0]     r_step;
    logic [1:0]     n_step;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [3:0]     r_stack [sirs_pkg::DIGIT_SLOTS];

    logic [31:0]    w_quo;
    logic [3:0]     w_rem;
    logic           w_digit_wr;
    logic [IW-1:0]  w_rd_idx;

    sirs_pkg::t_char r_oq [2];
    logic            r_oq_wp;
    logic            r_oq_rp;
    logic [1:0]      r_oq_cnt;
    logic [1:0]      n_oq_cnt;
    logic            w_oq_space;
    logic            w_oq_wr;
    logic            w_oq_rd;
    sirs_pkg::t_char w_oq_data;

    // eight quotient bits per cycle, restoring
    always_comb begin
        logic [31:0] w;
        logic [4:0]  t;
        logic [3:0]  rem;
        w   = r_work;
        rem = r_rem;
        for (int k = 0; k < sirs_pkg::CHUNK_BITS; k++) begin
            t = {rem, w[31]};
            w = {w[30:0], 1'b0};
            if (t >= i_cfg.radix) begin
                t    = t - i_cfg.radix;
                w[0] = 1'b1;
            end
            rem = t[3:0];
        end
        w_quo = w;
        w_rem = rem;
    end

    assign w_oq_space = (r_oq_cnt != 2'd2);
    assign w_rd_idx   = IW'(r_cnt - CW'(1));

    always_comb begin
        n_state    = r_state;
        n_work     = r_work;
        n_rem      = r_rem;
        n_step     = r_step;
        n_cnt      = r_cnt;
        o_take     = 1'b0;
        w_oq_wr    = 1'b0;
        w_digit_wr = 1'b0;
        w_oq_data  = '{ch: sirs_pkg::CH_MINUS, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    if (i_alpha_ok) begin
                        n_work  = i_item.mag;
                        n_rem   = 4'd0;
                        n_step  = 2'd0;
                        n_cnt   = '0;
                        n_state = i_item.neg ? S_SIGN : S_DIV;
                    end
                end
            end
            S_SIGN: begin
                if (w_oq_space) begin
                    w_oq_wr = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_work = w_quo;
                n_rem  = w_rem;
                n_step = r_step + 2'd1;
                if (r_step == 2'(sirs_pkg::DIV_CHUNKS - 1)) begin
                    w_digit_wr = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                    n_rem      = 4'd0;
                    if (w_quo == 32'd0 || r_cnt == CW'(sirs_pkg::DIGIT_SLOTS - 1)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                w_oq_data.ch   = sirs_pkg::sym_at(i_cfg.syms, r_stack[w_rd_idx]);
                w_oq_data.last = (r_cnt == CW'(1));
                if (w_oq_space) begin
                    w_oq_wr = 1'b1;
                    n_cnt   = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        if (w_digit_wr) begin
            r_stack[r_cnt[IW-1:0]] <= w_rem;
        end
    end

    // output word queue
    assign o_empty     = (r_oq_cnt == 2'd0);
    assign w_oq_rd     = i_pop && !o_empty;
    assign o_char_out  = r_oq[r_oq_rp].ch;
    assign o_last_char = r_oq[r_oq_rp].last;

    always_comb begin
        n_oq_cnt = r_oq_cnt;
        if (w_oq_wr && !w_oq_rd) begin
            n_oq_cnt = r_oq_cnt + 2'd1;
        end else if (w_oq_rd && !w_oq_wr) begin
            n_oq_cnt = r_oq_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_oq_cnt <= n_oq_cnt;
            if (w_oq_wr) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (w_oq_rd) begin
                r_oq_rp <= ~r_oq_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_wr) begin
            r_oq[r_oq_wp] <= w_oq_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/signed_int_to_radix_symbols_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed 32-bit integer to text in a configurable radix.
// Input: drive i_value with push high; the word is taken on a clock edge where
// full is low. Output: while empty is low, o_char_out / o_last_char show the
// oldest character; pop high takes it. o_last_char marks the final character
// of a number. A negative number starts with '-'.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 radix,
// 1 symbols 0..7, 2 symbols 8..15); write only while no number is in flight.
// An invalid alphabet makes numbers produce no characters at all.
// Flow: a two-entry input queue feeds a conversion engine that strips
// eight quotient bits per cycle, so each digit takes one pass over the word;
// digits then leave at one per cycle, while the output queue has space, into
// a two-entry output queue. The first digit appears only after all digits of
// a number are computed; a leading '-' is queued before division starts.
// Reset clears both queues and returns radix and alphabet to decimal
// "0123456789ABCDEF". A stalled receiver fills the output queue, which
// halts the engine, then the input queue, which raises full.
module signed_int_to_radix_symbols_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              o_char_out,
    output logic                    o_last_char,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);

    logic [4:0]      r_radix;
    logic [63:0]     r_sym_lo;
    logic [63:0]     r_sym_hi;
    logic            r_alpha_ok;
    logic            n_alpha_ok;
    sirs_pkg::t_cfg  w_cfg;
    sirs_pkg::t_item w_item;
    logic            w_valid;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= sirs_pkg::RADIX_RST;
            r_sym_lo <= sirs_pkg::SYM_LO_RST;
            r_sym_hi <= sirs_pkg::SYM_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sirs_pkg::REG_RADIX:  r_radix  <= i_cfg_data[4:0];
                sirs_pkg::REG_SYM_LO: r_sym_lo <= i_cfg_data;
                sirs_pkg::REG_SYM_HI: r_sym_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.radix = r_radix;
    assign w_cfg.syms  = {r_sym_hi, r_sym_lo};

    // radix range and alphabet check over the symbols in use
    always_comb begin
        logic [7:0] si;
        n_alpha_ok = (r_radix >= sirs_pkg::RADIX_MIN) && (r_radix <= sirs_pkg::RADIX_MAX);
        for (int i = 0; i < sirs_pkg::MAX_SYMBOLS; i++) begin
            si = sirs_pkg::sym_at(w_cfg.syms, 4'(i));
            if (5'(i) < r_radix) begin
                if (si == sirs_pkg::CH_NUL || si == sirs_pkg::CH_PLUS
                        || si == sirs_pkg::CH_MINUS) begin
                    n_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sirs_pkg::MAX_SYMBOLS; j++) begin
                    if (5'(j) < r_radix && sirs_pkg::sym_at(w_cfg.syms, 4'(j)) == si) begin
                        n_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ok <= 1'b1;
        end else begin
            r_alpha_ok <= n_alpha_ok;
        end
    end

    sirs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_value (i_value),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    sirs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_alpha_ok  (r_alpha_ok),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_char_out  (o_char_out),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

>>> rtl/sirs_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sirs_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [7:0]        o_char_out,
    input wire logic              o_last_char
);

    // reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset empties the input queue
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    // an untaken word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_char_out) && $stable(o_last_char)))
        else $error("waiting word changed or vanished");

endmodule

bind signed_int_to_radix_symbols_core sirs_chk u_sirs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_char_out  (o_char_out),
    .o_last_char (o_last_char)
);

`default_nettype wire
